FILE: design/bnv_pkg.sv
// Shared types and fixed-point constants for the BGR to NV12 converter.
// No dependencies; imported by every module of the block.
package bnv_pkg;

   // Configuration register indexes
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // Reset geometry
   localparam logic [12:0] RESET_WIDTH  = 13'd640;
   localparam logic [12:0] RESET_HEIGHT = 13'd480;
   localparam logic [13:0] HEIGHT_LIMIT = 14'd4096;

   // Q16 coefficients
   localparam logic [15:0] KY_R = 16'd16843;
   localparam logic [15:0] KY_G = 16'd33030;
   localparam logic [15:0] KY_B = 16'd6423;
   localparam logic [15:0] KU_R = 16'd9699;
   localparam logic [15:0] KU_G = 16'd19071;
   localparam logic [15:0] KU_B = 16'd28770;
   localparam logic [15:0] KV_R = 16'd28770;
   localparam logic [15:0] KV_G = 16'd24117;
   localparam logic [15:0] KV_B = 16'd4653;

   // 127.5 in Q18
   localparam logic signed [27:0] CHROMA_BIAS = 28'sd33423360;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Horizontal pair sums; blue sits in the low bits
   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
   } pair_type;

   typedef struct packed {
      logic chroma;     // odd row, odd column: block complete
      logic frame_end;  // last pixel of the frame
   } ctrl_type;

endpackage

FILE: design/bgr_to_nv12_converter.sv
// Top level of the streaming BGR to NV12 converter.
// Instantiates bnv_front, bnv_line_store and bnv_math; uses bnv_pkg.
//
//  port group | direction | carries
//  -----------+-----------+-------------------------------------------------
//  req_*      | in        | one BGR pixel per request, raster order
//  rsp_*      | out       | luma, block chroma U/V with flag, frame end
//  csr_*      | in        | frame width (index 0), frame height (index 1)
//
// One pixel accepted per clock when the result side keeps up; a request
// passes three registers (input, product, result). The line store sees
// one write or one read per odd-column pixel, none on even columns.
// Reset clears counters, pipeline valids and restores 640x480; the line
// store keeps its contents and needs no clearing. A stall on rsp_ready
// fills the empty stages first, then holds req_ready low.
// A register write restarts the frame at column 0, row 0.
module bgr_to_nv12_converter #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_luma,
   output logic        rsp_chroma_valid,
   output logic [7:0]  rsp_chroma_u,
   output logic [7:0]  rsp_chroma_v,
   output logic        rsp_frame_end
);
   import bnv_pkg::*;

   // line store holds one pair-sum entry per column pair
   localparam int DEPTH  = MAX_WIDTH / 2;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   pixel_type         req_pixel;
   logic              down_ready;
   logic              s1_valid;
   pixel_type         s1_pixel;
   pair_type          s1_pair;
   ctrl_type          s1_ctrl;
   logic              st_wr_en;
   logic              st_rd_en;
   logic [ADDR_W-1:0] st_addr;
   pair_type          st_wr_data;
   pair_type          st_rd_data;

   assign req_pixel.blue  = req_blue;
   assign req_pixel.green = req_green;
   assign req_pixel.red   = req_red;

   // counters, left pixel and pair sums; even rows write the store,
   // odd rows read it back on the odd column
   bnv_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .down_ready (down_ready),
      .s1_valid   (s1_valid),
      .s1_pixel   (s1_pixel),
      .s1_pair    (s1_pair),
      .s1_ctrl    (s1_ctrl),
      .st_wr_en   (st_wr_en),
      .st_rd_en   (st_rd_en),
      .st_addr    (st_addr),
      .st_wr_data (st_wr_data)
   );

   // read data lines up with the input register of the same request
   bnv_line_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .rd_en   (st_rd_en),
      .addr    (st_addr),
      .wr_data (st_wr_data),
      .rd_data (st_rd_data)
   );

   // products, then sums with floor and clamp into the result register
   bnv_math u_math (
      .clock            (clock),
      .reset            (reset),
      .s1_valid         (s1_valid),
      .s1_pixel         (s1_pixel),
      .s1_pair          (s1_pair),
      .s1_ctrl          (s1_ctrl),
      .st_rd_data       (st_rd_data),
      .up_ready         (down_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_chroma_u     (rsp_chroma_u),
      .rsp_chroma_v     (rsp_chroma_v),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

FILE: design/bnv_line_store.sv
// Line store of horizontal pair sums from the even row of each block row.
// Single write or read per cycle, registered read. Uses bnv_pkg.
module bnv_line_store #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   addr,
   input  bnv_pkg::pair_type   wr_data,
   output bnv_pkg::pair_type   rd_data
);
   import bnv_pkg::*;

   pair_type mem_ff [DEPTH];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bnv_front.sv
// Front stage: geometry registers, raster counters, left pixel, pair sums
// and the input register. Drives the line store. Uses bnv_pkg.
module bnv_front #(
   parameter  int MAX_WIDTH = 4096,
   localparam int ADDR_W    = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [12:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  bnv_pkg::pixel_type  req_pixel,
   input  logic                down_ready,
   output logic                s1_valid,
   output bnv_pkg::pixel_type  s1_pixel,
   output bnv_pkg::pair_type   s1_pair,
   output bnv_pkg::ctrl_type   s1_ctrl,
   output logic                st_wr_en,
   output logic                st_rd_en,
   output logic [ADDR_W-1:0]   st_addr,
   output bnv_pkg::pair_type   st_wr_data
);
   import bnv_pkg::*;

   localparam int CW = ADDR_W + 1;
   localparam logic [13:0] WIDTH_LIMIT = 14'(MAX_WIDTH);

   // even, clamped width minus one
   function automatic logic [CW-1:0] width_last(input logic [12:0] v);
      logic [13:0] x;
      x = {1'b0, v};
      if (x < 14'd2) x = 14'd2;
      if (x > WIDTH_LIMIT) x = WIDTH_LIMIT;
      x[0] = 1'b0;
      x = x - 14'd1;
      return x[CW-1:0];
   endfunction

   function automatic logic [11:0] height_last(input logic [12:0] v);
      logic [13:0] x;
      x = {1'b0, v};
      if (x < 14'd2) x = 14'd2;
      if (x > HEIGHT_LIMIT) x = HEIGHT_LIMIT;
      x[0] = 1'b0;
      x = x - 14'd1;
      return x[11:0];
   endfunction

   logic [CW-1:0] wlast_ff, wlast_in;
   logic [11:0]   hlast_ff, hlast_in;
   logic [CW-1:0] col_ff, col_in;
   logic [11:0]   row_ff, row_in;
   pixel_type     left_ff, left_in;
   logic          s1_valid_ff, s1_valid_in;
   pixel_type     s1_pixel_ff;
   pair_type      s1_pair_ff;
   ctrl_type      s1_ctrl_ff;

   logic     accept;
   logic     col_end;
   logic     row_end;
   pair_type pair;
   ctrl_type ctrl;

   assign req_ready = !s1_valid_ff || down_ready;
   assign accept    = req_valid && req_ready;
   assign col_end   = (col_ff == wlast_ff);
   assign row_end   = (row_ff == hlast_ff);

   assign pair.blue  = {1'b0, left_ff.blue}  + {1'b0, req_pixel.blue};
   assign pair.green = {1'b0, left_ff.green} + {1'b0, req_pixel.green};
   assign pair.red   = {1'b0, left_ff.red}   + {1'b0, req_pixel.red};

   assign ctrl.chroma    = col_ff[0] && row_ff[0];
   assign ctrl.frame_end = col_end && row_end;

   assign st_wr_en   = accept && col_ff[0] && !row_ff[0];
   assign st_rd_en   = accept && col_ff[0] && row_ff[0];
   assign st_addr    = col_ff[CW-1:1];
   assign st_wr_data = pair;

   always_comb begin
      wlast_in    = wlast_ff;
      hlast_in    = hlast_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      s1_valid_in = s1_valid_ff;
      if (down_ready) s1_valid_in = 1'b0;
      if (accept) begin
         s1_valid_in = 1'b1;
         if (!col_ff[0]) left_in = req_pixel;
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      // a register write restarts the frame; the line store is kept
      if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  wlast_in = width_last(csr_wdata);
            REG_FRAME_HEIGHT: hlast_in = height_last(csr_wdata);
            default:          ;
         endcase
         col_in  = '0;
         row_in  = '0;
         left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff    <= width_last(RESET_WIDTH);
         hlast_ff    <= height_last(RESET_HEIGHT);
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wlast_ff    <= wlast_in;
         hlast_ff    <= hlast_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_pair_ff  <= pair;
         s1_ctrl_ff  <= ctrl;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_pixel = s1_pixel_ff;
   assign s1_pair  = s1_pair_ff;
   assign s1_ctrl  = s1_ctrl_ff;

endmodule

FILE: design/bnv_math.sv
// Colour arithmetic: product stage, then sum, floor and clamp into the
// result register. Uses bnv_pkg.
module bnv_math (
   input  logic                clock,
   input  logic                reset,
   input  logic                s1_valid,
   input  bnv_pkg::pixel_type  s1_pixel,
   input  bnv_pkg::pair_type   s1_pair,
   input  bnv_pkg::ctrl_type   s1_ctrl,
   input  bnv_pkg::pair_type   st_rd_data,
   output logic                up_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_luma,
   output logic                rsp_chroma_valid,
   output logic [7:0]          rsp_chroma_u,
   output logic [7:0]          rsp_chroma_v,
   output logic                rsp_frame_end
);
   import bnv_pkg::*;

   function automatic logic [7:0] chroma_byte(input logic signed [27:0] acc);
      logic [9:0] t;
      t = acc[27:18];
      if (acc < 0) return 8'd0;
      if (t > 10'd255) return 8'd255;
      return t[7:0];
   endfunction

   // stage 2: products
   logic       s2_valid_ff, s2_valid_in;
   ctrl_type   s2_ctrl_ff;
   logic [23:0] py_r_ff, py_g_ff, py_b_ff;
   logic [25:0] pu_r_ff, pu_g_ff, pu_b_ff;
   logic [25:0] pv_r_ff, pv_g_ff, pv_b_ff;

   // stage 3: result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] luma_ff, cu_ff, cv_ff;
   logic       cvalid_ff, fend_ff;

   logic       out_free;
   logic       s2_free;
   logic [9:0] tb, tg, tr;
   logic [24:0] ysum;
   logic [8:0]  yfl;
   logic [7:0]  luma_in;
   logic signed [27:0] u_acc, v_acc;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign up_ready = s2_free;

   // four-pixel channel sums
   assign tb = {1'b0, s1_pair.blue}  + {1'b0, st_rd_data.blue};
   assign tg = {1'b0, s1_pair.green} + {1'b0, st_rd_data.green};
   assign tr = {1'b0, s1_pair.red}   + {1'b0, st_rd_data.red};

   always_comb begin
      s2_valid_in  = s2_free ? s1_valid : s2_valid_ff;
      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid) begin
         s2_ctrl_ff <= s1_ctrl;
         py_r_ff <= 24'(KY_R) * 24'(s1_pixel.red);
         py_g_ff <= 24'(KY_G) * 24'(s1_pixel.green);
         py_b_ff <= 24'(KY_B) * 24'(s1_pixel.blue);
         pu_r_ff <= 26'(KU_R) * 26'(tr);
         pu_g_ff <= 26'(KU_G) * 26'(tg);
         pu_b_ff <= 26'(KU_B) * 26'(tb);
         pv_r_ff <= 26'(KV_R) * 26'(tr);
         pv_g_ff <= 26'(KV_G) * 26'(tg);
         pv_b_ff <= 26'(KV_B) * 26'(tb);
      end
   end

   assign ysum = {1'b0, py_r_ff} + {1'b0, py_g_ff} + {1'b0, py_b_ff};
   assign yfl  = ysum[24:16];
   assign luma_in = (yfl > 9'd255) ? 8'd255 : yfl[7:0];

   assign u_acc = $signed({2'b00, pu_b_ff}) - $signed({2'b00, pu_r_ff})
                - $signed({2'b00, pu_g_ff}) + CHROMA_BIAS;
   assign v_acc = $signed({2'b00, pv_r_ff}) - $signed({2'b00, pv_g_ff})
                - $signed({2'b00, pv_b_ff}) + CHROMA_BIAS;

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         luma_ff   <= luma_in;
         cvalid_ff <= s2_ctrl_ff.chroma;
         cu_ff     <= s2_ctrl_ff.chroma ? chroma_byte(u_acc) : 8'd0;
         cv_ff     <= s2_ctrl_ff.chroma ? chroma_byte(v_acc) : 8'd0;
         fend_ff   <= s2_ctrl_ff.frame_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_luma         = luma_ff;
   assign rsp_chroma_valid = cvalid_ff;
   assign rsp_chroma_u     = cu_ff;
   assign rsp_chroma_v     = cv_ff;
   assign rsp_frame_end    = fend_ff;

endmodule

FILE: verif/bgr_to_nv12_converter_tb.sv
// Self-checking testbench for bgr_to_nv12_converter: pixel requests are checked
// against a behavioural predictor of luma, 2x2 block chroma and frame end.
// Depends on design/bnv_pkg.sv and the converter RTL.
`timescale 1ns / 1ps

module bgr_to_nv12_converter_tb;
   import bnv_pkg::*;

   localparam int          FRAME_MAX_WIDTH = 4096;
   localparam int unsigned SETTLE_CYCLES   = 8;     // three-stage pipe plus margin
   localparam int unsigned HOLD_CYCLES     = 250;   // long result-side hold-off
   localparam int unsigned RANDOM_PIXELS   = 380;

   // Chroma coefficients widened to signed 64 bits for the Q18 sums
   localparam longint CU_R = KU_R;
   localparam longint CU_G = KU_G;
   localparam longint CU_B = KU_B;
   localparam longint CV_R = KV_R;
   localparam longint CV_G = KV_G;
   localparam longint CV_B = KV_B;
   localparam longint BIAS_Q18 = CHROMA_BIAS;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       frame_end;
   } nv12_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [12:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_blue;
   logic [7:0]  req_green;
   logic [7:0]  req_red;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_luma;
   logic        rsp_chroma_valid;
   logic [7:0]  rsp_chroma_u;
   logic [7:0]  rsp_chroma_v;
   logic        rsp_frame_end;

   bgr_to_nv12_converter #(.MAX_WIDTH(FRAME_MAX_WIDTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_chroma_u     (rsp_chroma_u),
      .rsp_chroma_v     (rsp_chroma_v),
      .rsp_frame_end    (rsp_frame_end)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: shadow registers, raster position, left pixel of the
   // current pair and the line of pair sums left by the even row.
   // ---------------------------------------------------------------------
   logic [12:0] cfg_width;
   logic [12:0] cfg_height;
   int unsigned col_pos;
   int unsigned row_pos;
   pixel_type   left_px;
   pair_type    pair_sums [0:FRAME_MAX_WIDTH/2-1];

   nv12_result_type nv12_expected [$];

   // Bookkeeping for the summary and the verdict
   int unsigned error_count;
   int unsigned sent_count;
   int unsigned csr_count;
   int unsigned chroma_count;
   int unsigned frame_count;
   int unsigned input_stalls;

   // Sender pacing and the result-side hold-off request
   int unsigned burst_left;
   bit          gaps_on;
   bit          hold_rsp;

   // Effective frame dimension: at least two, saturated, rounded down to even
   function automatic int unsigned frame_dim(logic [12:0] raw, int unsigned limit);
      int unsigned v;
      v = raw;
      if (v < 2) v = 2;
      if (v > limit) v = limit;
      return v & 32'hFFFF_FFFE;
   endfunction

   // Q18 block sum plus 127.5 offset, floored and clamped to a byte
   function automatic logic [7:0] chroma_level(longint acc);
      longint t;
      t = acc + BIAS_Q18;
      if (t < 0) return 8'd0;
      t = t >>> 18;
      if (t > 255) return 8'd255;
      return t[7:0];
   endfunction

   // Works out the result of one accepted pixel and advances the raster position
   function automatic nv12_result_type convert_pixel(pixel_type px);
      nv12_result_type res;
      int unsigned y_acc;
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned slot;
      pair_type    pair;
      pair_type    upper;
      longint      sum_b;
      longint      sum_g;
      longint      sum_r;
      res   = '0;
      w_eff = frame_dim(cfg_width, FRAME_MAX_WIDTH);
      h_eff = frame_dim(cfg_height, HEIGHT_LIMIT);

      y_acc    = (KY_R * px.red + KY_G * px.green + KY_B * px.blue) >> 16;
      res.luma = (y_acc > 255) ? 8'd255 : y_acc[7:0];

      if (col_pos[0] == 1'b0) begin
         left_px = px;
      end else begin
         pair.blue  = left_px.blue + px.blue;
         pair.green = left_px.green + px.green;
         pair.red   = left_px.red + px.red;
         slot       = col_pos >> 1;
         if (row_pos[0] == 1'b0) begin
            pair_sums[slot] = pair;
         end else begin
            upper = pair_sums[slot];
            sum_b = pair.blue + upper.blue;
            sum_g = pair.green + upper.green;
            sum_r = pair.red + upper.red;
            res.chroma_u     = chroma_level(-CU_R * sum_r - CU_G * sum_g + CU_B * sum_b);
            res.chroma_v     = chroma_level(CV_R * sum_r - CV_G * sum_g - CV_B * sum_b);
            res.chroma_valid = 1'b1;
         end
      end

      col_pos++;
      if (col_pos >= w_eff) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h_eff) begin
            row_pos       = 0;
            res.frame_end = 1'b1;
         end
      end
      return res;
   endfunction

   // Channel byte weighted towards the extremes
   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.blue  = random_channel();
      px.green = random_channel();
      px.red   = random_channel();
      return px;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Entered and left at a falling edge. Valid is raised once
   // per request and only dropped for a gap between bursts.
   // ---------------------------------------------------------------------
   task automatic send_pixel(pixel_type px);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_blue  <= px.blue;
      req_green <= px.green;
      req_red   <= px.red;
      @(posedge clock);
      while (!req_ready) begin
         input_stalls++;
         @(posedge clock);
      end
      nv12_expected.push_back(convert_pixel(px));
      sent_count++;
      @(negedge clock);
   endtask

   // Drop valid, let every expected result arrive, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (nv12_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; only called with the converter idle. Either register
   // restarts the frame, the line store is kept.
   task automatic write_csr(logic idx, logic [12:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_FRAME_WIDTH) cfg_width = value;
      else cfg_height = value;
      col_pos = 0;
      row_pos = 0;
      left_px = '0;
      csr_count++;
      @(negedge clock);
   endtask

   task automatic set_geometry(logic [12:0] w, logic [12:0] h);
      write_csr(REG_FRAME_WIDTH, w);
      write_csr(REG_FRAME_HEIGHT, h);
   endtask

   // Width-4 frame of two flat 2x2 blocks
   task automatic send_two_blocks(pixel_type a, pixel_type b);
      repeat (2) begin
         send_pixel(a);
         send_pixel(a);
         send_pixel(b);
         send_pixel(b);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // 640 wide after reset: a short run inside the first row must give luma
   // only, with no row wrap, chroma or frame end
   task automatic test_reset_geometry();
      repeat (16) send_pixel(random_pixel());
      wait_idle();
   endtask

   // Flat blocks at the corners of the colour space: U high and low, V high
   // and low; then one 2x2 block of mixed black and white pixels
   task automatic test_colour_extremes();
      set_geometry(13'd4, 13'd2);
      send_two_blocks('{red: 8'd0, green: 8'd0, blue: 8'd255},
                      '{red: 8'd255, green: 8'd0, blue: 8'd0});
      send_two_blocks('{red: 8'd255, green: 8'd255, blue: 8'd0},
                      '{red: 8'd0, green: 8'd255, blue: 8'd255});
      wait_idle();
      set_geometry(13'd2, 13'd2);
      send_pixel('{red: 8'd0, green: 8'd0, blue: 8'd0});
      send_pixel('{red: 8'd255, green: 8'd255, blue: 8'd255});
      send_pixel('{red: 8'd255, green: 8'd255, blue: 8'd255});
      send_pixel('{red: 8'd0, green: 8'd0, blue: 8'd0});
      wait_idle();
   endtask

   // Zero and one treated as two; odd sizes rounded down
   task automatic test_dimension_clamps();
      set_geometry(13'd0, 13'd1);
      repeat (8) send_pixel(random_pixel());
      wait_idle();
      set_geometry(13'd7, 13'd3);
      repeat (12) send_pixel(random_pixel());
      wait_idle();
   endtask

   // Rewrite of a register part way into a frame starts again at row 0
   task automatic test_restart_mid_frame();
      set_geometry(13'd6, 13'd4);
      repeat (9) send_pixel(random_pixel());
      wait_idle();
      write_csr(REG_FRAME_WIDTH, 13'd6);
      repeat (24) send_pixel(random_pixel());
      wait_idle();
   endtask

   // Result side held off for a long stretch while requests keep coming
   task automatic test_backpressure();
      gaps_on = 1'b0;
      set_geometry(13'd8, 13'd4);
      hold_rsp = 1'b1;
      repeat (32) send_pixel(random_pixel());
      wait_idle();
      gaps_on = 1'b1;
   endtask

   // Oversized registers saturate rather than wrap: a stretch of a very wide
   // line gives no early row wrap, and a very tall frame of width two keeps
   // giving chroma with no early frame end
   task automatic test_dimension_limits();
      set_geometry(13'd8191, 13'd2);
      repeat (48) send_pixel(random_pixel());
      wait_idle();
      set_geometry(13'd2, 13'd8191);
      repeat (48) send_pixel(random_pixel());
      wait_idle();
   endtask

   // Mostly small whole frames (one or two back to back), some cut short by
   // the next register write, now and then odd or degenerate sizes
   task automatic test_random_frames();
      int unsigned pix_total;
      int unsigned n;
      logic [12:0] w_raw;
      logic [12:0] h_raw;
      pix_total = 0;
      while (pix_total < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       w_raw = 13'($urandom_range(0, 3));
            1:       w_raw = 13'($urandom_range(25, 160));
            default: w_raw = 13'(2 * $urandom_range(1, 12));
         endcase
         if (w_raw > 24) begin
            h_raw = 13'($urandom_range(0, 3));
         end else begin
            case ($urandom_range(0, 7))
               0:       h_raw = 13'($urandom_range(0, 3));
               1:       h_raw = 13'($urandom_range(9, 13));
               default: h_raw = 13'(2 * $urandom_range(1, 4));
            endcase
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1) == 0) begin
            set_geometry(w_raw, h_raw);
         end else begin
            write_csr(REG_FRAME_HEIGHT, h_raw);
            write_csr(REG_FRAME_WIDTH, w_raw);
         end
         n = frame_dim(w_raw, FRAME_MAX_WIDTH) * frame_dim(h_raw, HEIGHT_LIMIT);
         if ($urandom_range(0, 6) == 0) n = $urandom_range(1, n - 1);
         else n = n * $urandom_range(1, 2);
         repeat (n) send_pixel(random_pixel());
         pix_total += n;
         wait_idle();
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Result side: a pattern that changes mode every so often, plus the long
   // hold-off when a test asks for it. Driven at the falling edge.
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      int unsigned mode;
      int unsigned span;
      int unsigned phase;
      rsp_ready = 1'b0;
      mode      = 0;
      span      = 0;
      phase     = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(20, 200);
            end
            span--;
            phase++;
            case (mode)
               0:       rsp_ready <= 1'b1;                           // no stalls
               1:       rsp_ready <= ($urandom_range(0, 9) < 7);     // light stalls
               2:       rsp_ready <= ($urandom_range(0, 9) < 3);     // heavy stalls
               default: rsp_ready <= (phase % 3 == 0);               // one in three
            endcase
         end
      end
   end

   // Result checker: each accepted result against the oldest expectation
   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      nv12_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (nv12_expected.size() == 0) begin
            $display("%0t: result with nothing expected, luma %0d", $time, rsp_luma);
            error_count++;
         end else begin
            want = nv12_expected.pop_front();
            check_field("luma", want.luma, rsp_luma);
            check_field("chroma_valid", want.chroma_valid, rsp_chroma_valid);
            check_field("chroma_u", want.chroma_u, rsp_chroma_u);
            check_field("chroma_v", want.chroma_v, rsp_chroma_v);
            check_field("frame_end", want.frame_end, rsp_frame_end);
            if (want.chroma_valid) chroma_count++;
            if (want.frame_end) frame_count++;
         end
      end
   end

   // Watchdog, well beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("bgr_to_nv12_converter: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = REG_FRAME_WIDTH;
      csr_wdata    = '0;
      req_valid    = 1'b0;
      req_blue     = '0;
      req_green    = '0;
      req_red      = '0;
      cfg_width    = RESET_WIDTH;
      cfg_height   = RESET_HEIGHT;
      col_pos      = 0;
      row_pos      = 0;
      left_px      = '0;
      error_count  = 0;
      sent_count   = 0;
      csr_count    = 0;
      chroma_count = 0;
      frame_count  = 0;
      input_stalls = 0;
      burst_left   = 0;
      gaps_on      = 1'b1;
      hold_rsp     = 1'b0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_geometry();
      test_colour_extremes();
      test_dimension_clamps();
      test_restart_mid_frame();
      test_backpressure();
      test_dimension_limits();
      test_random_frames();

      $display("covered %0d pixel requests and %0d register writes:",
               sent_count, csr_count);
      $display("%0d chroma blocks, %0d frames, request side held off for %0d cycles",
               chroma_count, frame_count, input_stalls);
      if (error_count == 0) begin
         $display("bgr_to_nv12_converter: match");
      end else begin
         $display("bgr_to_nv12_converter: mismatch");
      end
      $finish;
   end

endmodule
